### hw/rtl/mcmt_pkg.sv
// ----------------------------------------------------------------------------
// Match timer package
// Shared types, codes and sizes of the multi-channel match timer.
// ----------------------------------------------------------------------------
package mcmt_pkg;

	localparam int NUM_TIMERS = 4;
	localparam int CH_W       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CNT_W      = $clog2(NUM_TIMERS + 1);

	localparam int OP_W     = 2;
	localparam int TASK_W   = 8;
	localparam int EVENT_W  = 16;
	localparam int TIME_W   = 32;
	localparam int MODE_W   = 2;
	localparam int STATUS_W = 3;
	localparam int FCH_W    = 2;
	localparam int TIU_W    = 3;
	localparam int BIND_W   = TASK_W + EVENT_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = BIND_W;

	typedef enum logic [OP_W-1:0] {
		OP_ADVANCE = 2'd0,
		OP_SCAN    = 2'd1,
		OP_START   = 2'd2,
		OP_STOP    = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_BAD_TASK   = 3'd1,
		ST_ZERO_MATCH = 3'd2,
		ST_BAD_MODE   = 3'd3,
		ST_NOT_FOUND  = 3'd4
	} status_t;

	localparam logic [MODE_W-1:0] MODE_ONCE     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PERIODIC = 2'd1;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_SCAN   = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_TASK_COUNT    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMERS_IN_USE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BINDING_ZERO  = 3'd2;

	localparam logic [TASK_W-1:0] TASK_COUNT_RESET    = 8'd255;
	localparam logic [TIU_W-1:0]  TIMERS_IN_USE_RESET = 3'd4;

	// Result of evaluating one channel in the shared unit
	typedef struct packed {
		logic bind_hit;
		logic expired;
	} chan_eval_t;

endpackage

### hw/rtl/mcmt_if.sv
// ----------------------------------------------------------------------------
// Match timer channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mcmt_req_if import mcmt_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     op;
	logic [TASK_W-1:0]   task_id;
	logic [EVENT_W-1:0]  event_flag;
	logic [TIME_W-1:0]   match_value;
	logic [MODE_W-1:0]   timer_mode;

	modport source (output valid, op, task_id, event_flag, match_value, timer_mode,
		input ready);
	modport sink (input valid, op, task_id, event_flag, match_value, timer_mode,
		output ready);
endinterface

interface mcmt_rsp_if import mcmt_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                kind;
	logic [STATUS_W-1:0] status;
	logic                fired;
	logic [TASK_W-1:0]   fired_task;
	logic [EVENT_W-1:0]  fired_event;
	logic [FCH_W-1:0]    fired_channel;
	logic                last;

	modport source (output valid, kind, status, fired, fired_task, fired_event,
		fired_channel, last, input ready);
	modport sink (input valid, kind, status, fired, fired_task, fired_event,
		fired_channel, last, output ready);
endinterface

### hw/rtl/mcmt_chan_unit.sv
// ----------------------------------------------------------------------------
// Match timer channel unit
// Shared evaluator: binding compare and modular elapsed-time check of one channel.
// ----------------------------------------------------------------------------
module mcmt_chan_unit import mcmt_pkg::*; (
	input  logic [BIND_W-1:0]  binding,
	input  logic [TASK_W-1:0]  task_id,
	input  logic [EVENT_W-1:0] event_flag,
	input  logic               running,
	input  logic [TIME_W-1:0]  match_value,
	input  logic [TIME_W-1:0]  start_time,
	input  logic [TIME_W-1:0]  now,
	output chan_eval_t         result
);

	logic [TIME_W-1:0] elapsed;

	// Wraps naturally modulo 2^32
	assign elapsed = now - start_time;

	assign result.bind_hit = (binding[BIND_W-1:EVENT_W] == task_id) &&
		(binding[EVENT_W-1:0] == event_flag);
	assign result.expired = running && !(match_value > elapsed);

endmodule

### hw/rtl/multi_channel_match_timer.sv
// ----------------------------------------------------------------------------
// Multi-channel match timer
// Table of timer channels on a millisecond counter that advance requests step,
// with start, stop and scan requests.
// ----------------------------------------------------------------------------
// One request is handled at a time; req.ready is high only while the sequencer
// is idle. All channel work goes through one shared channel unit that looks at
// one channel per cycle unless a full output register holds it, so the work of
// a request follows the active channel count n = min(timers_in_use, NUM_TIMERS):
// an advance is done on acceptance; a start or stop is accepted, then searches
// up to n channels (a rejected request answers without searching); a scan is
// accepted, evaluates all n channels, then walks the channel positions up to the
// last fired one (or gives a single report for the "nothing fired" case).
// Each response waits in an output register; a stalled rsp.ready only holds
// the sequencer on the cycle it wants to emit. Configuration writes are taken
// at any time but are meant only while the block is idle.
// ----------------------------------------------------------------------------
module multi_channel_match_timer import mcmt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	mcmt_req_if.sink              req,
	mcmt_rsp_if.source            rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SEARCH = 4'b0010,
		S_SCAN   = 4'b0100,
		S_FIRE   = 4'b1000
	} state_t;

	state_t state_q;

	// configuration
	logic [TASK_W-1:0] task_count_q;
	logic [TIU_W-1:0]  timers_in_use_q;
	logic [BIND_W-1:0] binding_q [NUM_TIMERS];

	// timer state
	logic [TIME_W-1:0] ms_count_q;
	logic [NUM_TIMERS-1:0] running_q;
	logic [NUM_TIMERS-1:0] periodic_q;
	logic [TIME_W-1:0] match_q [NUM_TIMERS];
	logic [TIME_W-1:0] start_q [NUM_TIMERS];

	// latched request
	op_t               op_q;
	logic [TASK_W-1:0] task_q;
	logic [EVENT_W-1:0] event_q;
	logic [TIME_W-1:0] match_val_q;
	logic [MODE_W-1:0] mode_q;
	status_t           status_q;

	logic [CNT_W-1:0]      idx_q;
	logic [NUM_TIMERS-1:0] fire_mask_q;

	// output register
	logic                rsp_valid_q;
	logic                kind_q;
	logic [STATUS_W-1:0] rsp_status_q;
	logic                fired_q;
	logic [TASK_W-1:0]   fired_task_q;
	logic [EVENT_W-1:0]  fired_event_q;
	logic [FCH_W-1:0]    fired_channel_q;
	logic                last_q;

	logic [CNT_W-1:0]      n_active;
	logic                  idx_done;
	logic [CH_W-1:0]       chan;
	chan_eval_t            eval;
	logic                  req_acc;
	status_t               pre_status;
	logic                  slot_free;
	logic [NUM_TIMERS-1:0] mask_rest;

	logic                emit;
	logic                e_kind;
	status_t             e_status;
	logic                e_fired;
	logic [TASK_W-1:0]   e_task;
	logic [EVENT_W-1:0]  e_event;
	logic [FCH_W-1:0]    e_chan;
	logic                e_last;
	logic                load;

	// Saturate the channel count at the table size
	assign n_active = (timers_in_use_q > TIU_W'(NUM_TIMERS)) ? CNT_W'(NUM_TIMERS)
		: CNT_W'(timers_in_use_q);
	assign idx_done = (idx_q >= n_active);
	assign chan     = (idx_q < CNT_W'(NUM_TIMERS)) ? idx_q[CH_W-1:0] : '0;

	mcmt_chan_unit u_chan_unit (
		.binding     (binding_q[chan]),
		.task_id     (task_q),
		.event_flag  (event_q),
		.running     (running_q[chan]),
		.match_value (match_q[chan]),
		.start_time  (start_q[chan]),
		.now         (ms_count_q),
		.result      (eval)
	);

	assign req.ready = (state_q == S_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign slot_free = !rsp_valid_q || rsp.ready;
	assign mask_rest = fire_mask_q & ~(NUM_TIMERS'(1) << chan);

	// Checks that do not need the table, in priority order
	always_comb begin
		pre_status = ST_OK;
		if (req.task_id >= task_count_q) begin
			pre_status = ST_BAD_TASK;
		end else if (op_t'(req.op) == OP_START) begin
			if (req.match_value == '0) begin
				pre_status = ST_ZERO_MATCH;
			end else if (req.timer_mode != MODE_ONCE && req.timer_mode != MODE_PERIODIC) begin
				pre_status = ST_BAD_MODE;
			end
		end
	end

	// Response the sequencer wants to emit this cycle
	always_comb begin
		emit     = 1'b0;
		e_kind   = KIND_STATUS;
		e_status = ST_OK;
		e_fired  = 1'b0;
		e_task   = '0;
		e_event  = '0;
		e_chan   = '0;
		e_last   = 1'b1;
		case (state_q)
			S_SEARCH: begin
				if (status_q != ST_OK) begin
					emit     = 1'b1;
					e_status = status_q;
				end else if (idx_done) begin
					emit     = 1'b1;
					e_status = ST_NOT_FOUND;
				end else if (eval.bind_hit) begin
					emit = 1'b1;
				end
			end
			S_FIRE: begin
				e_kind = KIND_SCAN;
				if (fire_mask_q == '0) begin
					emit = 1'b1;
				end else if (fire_mask_q[chan]) begin
					emit    = 1'b1;
					e_fired = 1'b1;
					e_task  = binding_q[chan][BIND_W-1:EVENT_W];
					e_event = binding_q[chan][EVENT_W-1:0];
					e_chan  = FCH_W'(chan);
					e_last  = (mask_rest == '0);
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign load = emit && slot_free;

	// Configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q    <= TASK_COUNT_RESET;
			timers_in_use_q <= TIMERS_IN_USE_RESET;
			for (int i = 0; i < NUM_TIMERS; i++) begin
				binding_q[i] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == REG_TASK_COUNT) begin
				task_count_q <= cfg_data[TASK_W-1:0];
			end
			if (cfg_index == REG_TIMERS_IN_USE) begin
				timers_in_use_q <= cfg_data[TIU_W-1:0];
			end
			for (int i = 0; i < NUM_TIMERS; i++) begin
				if (cfg_index == REG_BINDING_ZERO + CFG_IDX_W'(i)) begin
					binding_q[i] <= cfg_data[BIND_W-1:0];
				end
			end
		end
	end

	// Sequencer and timer table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ms_count_q  <= '0;
			running_q   <= '0;
			periodic_q  <= '0;
			idx_q       <= '0;
			fire_mask_q <= '0;
			op_q        <= OP_ADVANCE;
			task_q      <= '0;
			event_q     <= '0;
			match_val_q <= '0;
			mode_q      <= MODE_ONCE;
			status_q    <= ST_OK;
			for (int i = 0; i < NUM_TIMERS; i++) begin
				match_q[i] <= '0;
				start_q[i] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						op_q        <= op_t'(req.op);
						task_q      <= req.task_id;
						event_q     <= req.event_flag;
						match_val_q <= req.match_value;
						mode_q      <= req.timer_mode;
						status_q    <= pre_status;
						idx_q       <= '0;
						fire_mask_q <= '0;
						case (op_t'(req.op))
							OP_ADVANCE: ms_count_q <= ms_count_q + 1'b1;
							OP_SCAN:    state_q <= S_SCAN;
							default:    state_q <= S_SEARCH;
						endcase
					end
				end
				S_SEARCH: begin
					if (status_q != ST_OK || idx_done) begin
						if (slot_free) begin
							state_q <= S_IDLE;
						end
					end else if (eval.bind_hit) begin
						if (slot_free) begin
							// start arms the channel, stop clears it
							running_q[chan]  <= (op_q == OP_START);
							periodic_q[chan] <= (op_q == OP_START) && (mode_q == MODE_PERIODIC);
							match_q[chan]    <= (op_q == OP_START) ? match_val_q : '0;
							start_q[chan]    <= (op_q == OP_START) ? ms_count_q : '0;
							state_q          <= S_IDLE;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_SCAN: begin
					// evaluate one channel a cycle, then walk the fire mask
					if (idx_done) begin
						idx_q   <= '0;
						state_q <= S_FIRE;
					end else begin
						fire_mask_q[chan] <= eval.expired;
						idx_q             <= idx_q + 1'b1;
					end
				end
				S_FIRE: begin
					if (fire_mask_q == '0) begin
						if (slot_free) begin
							state_q <= S_IDLE;
						end
					end else if (fire_mask_q[chan]) begin
						if (slot_free) begin
							fire_mask_q <= mask_rest;
							if (periodic_q[chan]) begin
								start_q[chan] <= ms_count_q;
							end else begin
								running_q[chan] <= 1'b0;
								match_q[chan]   <= '0;
								start_q[chan]   <= '0;
							end
							if (mask_rest == '0) begin
								state_q <= S_IDLE;
							end else begin
								idx_q <= idx_q + 1'b1;
							end
						end
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register: hold the response until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q          <= e_kind;
			rsp_status_q    <= e_status;
			fired_q         <= e_fired;
			fired_task_q    <= e_task;
			fired_event_q   <= e_event;
			fired_channel_q <= e_chan;
			last_q          <= e_last;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.kind          = kind_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.fired         = fired_q;
	assign rsp.fired_task    = fired_task_q;
	assign rsp.fired_event   = fired_event_q;
	assign rsp.fired_channel = fired_channel_q;
	assign rsp.last          = last_q;

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// Match timer testbench
// Drives start, stop, scan and advance requests into the multi-channel match
// timer under several register settings, with random stalls on both channels,
// and checks every response field against a cycle-free model of the table.
// ----------------------------------------------------------------------------
module testbench import mcmt_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	// Request contents as the timer table sees them
	typedef struct {
		op_t                op;
		logic [TASK_W-1:0]  tid;
		logic [EVENT_W-1:0] flag;
		logic [TIME_W-1:0]  match;
		logic [MODE_W-1:0]  mode;
	} timer_req_t;

	// One response beat, field for field
	typedef struct packed {
		logic                kind;
		logic [STATUS_W-1:0] status;
		logic                fired;
		logic [TASK_W-1:0]   ftask;
		logic [EVENT_W-1:0]  fevent;
		logic [FCH_W-1:0]    fchan;
		logic                last;
	} timer_rsp_t;

	// A row of the directed plan: a register write or a request, the latter
	// optionally with its single response written out by hand
	typedef struct {
		logic                  is_write;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		timer_req_t            item;
		logic                  typed;
		timer_rsp_t            typed_rsp;
	} plan_row_t;

	localparam logic [MODE_W-1:0]    MODE_BAD_TWO   = 2'd2;
	localparam logic [MODE_W-1:0]    MODE_BAD_THREE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED     = 3'd7;
	localparam int NUM_PHASES      = 6;
	localparam int DRAIN_CYCLES    = 24;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam longint TIMEOUT_NS  = 5_000_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic rsp_ready = 1'b0;

	mcmt_req_if req_ch ();
	mcmt_rsp_if rsp_ch ();

	assign rsp_ch.ready = rsp_ready;

	multi_channel_match_timer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Timer table model: register copy and channel state
	// ------------------------------------------------------------------------
	logic [TASK_W-1:0] m_task_count;
	logic [TIU_W-1:0]  m_tiu;
	logic [BIND_W-1:0] m_bind [NUM_TIMERS];
	logic [TIME_W-1:0] m_ms;
	logic              m_run [NUM_TIMERS];
	logic              m_per [NUM_TIMERS];
	logic [TIME_W-1:0] m_match [NUM_TIMERS];
	logic [TIME_W-1:0] m_start [NUM_TIMERS];

	// Responses produced by the last modeled request
	timer_rsp_t step_rsp [NUM_TIMERS];
	int         step_cnt;

	// Responses still owed by the block, oldest first
	timer_rsp_t awaited_reports [$];

	int error_count = 0;
	int idle_pct = 0;
	bit hold_off_req = 1'b0;

	function automatic timer_rsp_t single_rsp(logic k, status_t s);
		timer_rsp_t r;
		r = '0;
		r.kind = k;
		r.status = s;
		r.last = 1'b1;
		return r;
	endfunction

	task automatic reset_timer_model();
		m_task_count = TASK_COUNT_RESET;
		m_tiu = TIMERS_IN_USE_RESET;
		m_ms = '0;
		for (int i = 0; i < NUM_TIMERS; i++) begin
			m_bind[i] = '0;
			m_run[i] = 1'b0;
			m_per[i] = 1'b0;
			m_match[i] = '0;
			m_start[i] = '0;
		end
	endtask

	task automatic write_timer_model(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		if (idx == REG_TASK_COUNT) begin
			m_task_count = val[TASK_W-1:0];
		end else if (idx == REG_TIMERS_IN_USE) begin
			m_tiu = val[TIU_W-1:0];
		end else if (idx >= REG_BINDING_ZERO && idx < REG_BINDING_ZERO + NUM_TIMERS) begin
			m_bind[idx - REG_BINDING_ZERO] = val;
		end
		// any other index: drop the write
	endtask

	// Apply one accepted request to the model and leave its responses in
	// step_rsp[0 .. step_cnt-1]
	task automatic step_timer_model(timer_req_t r);
		int n;
		int ch;
		status_t st;
		logic [TIME_W-1:0] elapsed;
		n = (m_tiu > NUM_TIMERS) ? NUM_TIMERS : int'(m_tiu);
		step_cnt = 0;
		case (r.op)
			OP_ADVANCE: begin
				m_ms = m_ms + 1'b1;
			end
			OP_SCAN: begin
				for (int i = 0; i < n; i++) begin
					elapsed = m_ms - m_start[i];
					if (m_run[i] && m_match[i] <= elapsed) begin
						step_rsp[step_cnt] = '0;
						step_rsp[step_cnt].kind = KIND_SCAN;
						step_rsp[step_cnt].status = ST_OK;
						step_rsp[step_cnt].fired = 1'b1;
						step_rsp[step_cnt].ftask = m_bind[i][BIND_W-1:EVENT_W];
						step_rsp[step_cnt].fevent = m_bind[i][EVENT_W-1:0];
						step_rsp[step_cnt].fchan = i[FCH_W-1:0];
						step_cnt++;
						if (m_per[i]) begin
							m_start[i] = m_ms;
						end else begin
							m_run[i] = 1'b0;
							m_match[i] = '0;
							m_start[i] = '0;
						end
					end
				end
				if (step_cnt == 0) begin
					step_rsp[0] = single_rsp(KIND_SCAN, ST_OK);
					step_cnt = 1;
				end else begin
					step_rsp[step_cnt-1].last = 1'b1;
				end
			end
			default: begin
				ch = -1;
				for (int i = n - 1; i >= 0; i--) begin
					if (m_bind[i] == {r.tid, r.flag})
						ch = i;
				end
				if (r.tid >= m_task_count) begin
					st = ST_BAD_TASK;
				end else if (r.op == OP_START && r.match == '0) begin
					st = ST_ZERO_MATCH;
				end else if (r.op == OP_START && r.mode > MODE_PERIODIC) begin
					st = ST_BAD_MODE;
				end else if (ch < 0) begin
					st = ST_NOT_FOUND;
				end else begin
					st = ST_OK;
					// stop clears the channel even when it is not running
					m_run[ch] = (r.op == OP_START);
					m_per[ch] = (r.op == OP_START) && (r.mode == MODE_PERIODIC);
					m_match[ch] = (r.op == OP_START) ? r.match : '0;
					m_start[ch] = (r.op == OP_START) ? m_ms : '0;
				end
				step_rsp[0] = single_rsp(KIND_STATUS, st);
				step_cnt = 1;
			end
		endcase
	endtask

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------
	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		error_count++;
	endtask

	// Compare each accepted response with the oldest one owed, then pick the
	// ready level for the next cycle: a long hold-off once, random stall
	// bursts while idling is allowed, otherwise always ready.
	int stall_left = 0;
	int hold_left = 0;
	bit hold_taken = 1'b0;

	always @(posedge clk) begin : response_side
		timer_rsp_t got;
		timer_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ready) begin
			got = {rsp_ch.kind, rsp_ch.status, rsp_ch.fired, rsp_ch.fired_task,
				rsp_ch.fired_event, rsp_ch.fired_channel, rsp_ch.last};
			if (awaited_reports.size() == 0) begin
				report_mismatch("unexpected response", got, '0);
			end else begin
				want = awaited_reports.pop_front();
				if (got.kind !== want.kind)
					report_mismatch("kind", got.kind, want.kind);
				if (got.status !== want.status)
					report_mismatch("status", got.status, want.status);
				if (got.fired !== want.fired)
					report_mismatch("fired", got.fired, want.fired);
				if (got.ftask !== want.ftask)
					report_mismatch("fired_task", got.ftask, want.ftask);
				if (got.fevent !== want.fevent)
					report_mismatch("fired_event", got.fevent, want.fevent);
				if (got.fchan !== want.fchan)
					report_mismatch("fired_channel", got.fchan, want.fchan);
				if (got.last !== want.last)
					report_mismatch("last", got.last, want.last);
			end
		end
		if (hold_off_req && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left = HOLD_OFF_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_ready <= 1'b0;
		end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			stall_left = $urandom_range(0, 5);
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers: all called at a rising edge
	// ------------------------------------------------------------------------

	// Offer a request, hold it until accepted, then record what it must produce
	task automatic send_request(timer_req_t r, logic typed, timer_rsp_t typed_rsp);
		req_ch.valid <= 1'b1;
		req_ch.op <= r.op;
		req_ch.task_id <= r.tid;
		req_ch.event_flag <= r.flag;
		req_ch.match_value <= r.match;
		req_ch.timer_mode <= r.mode;
		do
			@(posedge clk);
		while (!req_ch.ready);
		step_timer_model(r);
		if (typed) begin
			awaited_reports.push_back(typed_rsp);
		end else begin
			for (int i = 0; i < step_cnt; i++)
				awaited_reports.push_back(step_rsp[i]);
		end
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Drop valid and wait until the block has answered everything and settled
	task automatic drain_block();
		req_ch.valid <= 1'b0;
		while (awaited_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		write_timer_model(idx, val);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic plan_row_t plan_write(logic [CFG_IDX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] val);
		plan_row_t p;
		p.is_write = 1'b1;
		p.reg_idx = idx;
		p.reg_val = val;
		p.item = '{op: OP_ADVANCE, tid: '0, flag: '0, match: '0, mode: MODE_ONCE};
		p.typed = 1'b0;
		p.typed_rsp = '0;
		return p;
	endfunction

	function automatic plan_row_t plan_item(op_t op, logic [TASK_W-1:0] tid,
			logic [EVENT_W-1:0] flag, logic [TIME_W-1:0] match, logic [MODE_W-1:0] mode);
		plan_row_t p;
		p.is_write = 1'b0;
		p.reg_idx = '0;
		p.reg_val = '0;
		p.item = '{op: op, tid: tid, flag: flag, match: match, mode: mode};
		p.typed = 1'b0;
		p.typed_rsp = '0;
		return p;
	endfunction

	function automatic plan_row_t plan_typed(op_t op, logic [TASK_W-1:0] tid,
			logic [EVENT_W-1:0] flag, logic [TIME_W-1:0] match, logic [MODE_W-1:0] mode,
			timer_rsp_t want);
		plan_row_t p;
		p = plan_item(op, tid, flag, match, mode);
		p.typed = 1'b1;
		p.typed_rsp = want;
		return p;
	endfunction

	// Mostly requests aimed at bound channels with short match values, so
	// channels start, expire and rearm; the rest is random noise.
	function automatic timer_req_t random_request();
		timer_req_t r;
		int sel;
		int j;
		sel = $urandom_range(0, 99);
		if (sel < 35)
			r.op = OP_ADVANCE;
		else if (sel < 55)
			r.op = OP_SCAN;
		else if (sel < 82)
			r.op = OP_START;
		else
			r.op = OP_STOP;
		if ($urandom_range(0, 9) < 8) begin
			j = $urandom_range(0, NUM_TIMERS - 1);
			r.tid = m_bind[j][BIND_W-1:EVENT_W];
			r.flag = m_bind[j][EVENT_W-1:0];
		end else begin
			r.tid = 8'($urandom_range(0, 255));
			r.flag = 16'($urandom_range(0, 65535));
		end
		sel = $urandom_range(0, 19);
		if (sel == 0)
			r.match = '0;
		else if (sel == 1)
			r.match = $urandom;
		else
			r.match = $urandom_range(1, 6);
		if ($urandom_range(0, 11) == 0)
			r.mode = 2'($urandom_range(MODE_BAD_TWO, MODE_BAD_THREE));
		else
			r.mode = $urandom_range(0, 1) ? MODE_PERIODIC : MODE_ONCE;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin : stimulus
		plan_row_t plan [$];
		timer_rsp_t none;
		logic [TASK_W-1:0] tc;
		logic [TIU_W-1:0] tiu;
		logic [BIND_W-1:0] b [NUM_TIMERS];
		int phase_items [NUM_PHASES];

		none = '0;
		phase_items = '{90, 20, 70, 90, 30, 160};

		// Hold every input at a known level through reset
		req_ch.valid <= 1'b0;
		req_ch.op <= OP_ADVANCE;
		req_ch.task_id <= '0;
		req_ch.event_flag <= '0;
		req_ch.match_value <= '0;
		req_ch.timer_mode <= MODE_ONCE;
		cfg_we <= 1'b0;
		cfg_index <= REG_TASK_COUNT;
		cfg_data <= '0;
		reset_timer_model();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. After reset every binding is task 0, flag 0, so all
		// channels collide and the lowest one must win.
		plan.push_back(plan_typed(OP_SCAN, 8'h00, 16'h0000, 32'd0, MODE_ONCE,
			single_rsp(KIND_SCAN, ST_OK)));
		plan.push_back(plan_typed(OP_START, 8'h00, 16'h0000, 32'd0, MODE_ONCE,
			single_rsp(KIND_STATUS, ST_ZERO_MATCH)));
		plan.push_back(plan_typed(OP_START, 8'h00, 16'h0000, 32'd1, MODE_BAD_TWO,
			single_rsp(KIND_STATUS, ST_BAD_MODE)));
		plan.push_back(plan_typed(OP_START, 8'h00, 16'h0000, 32'd1, MODE_BAD_THREE,
			single_rsp(KIND_STATUS, ST_BAD_MODE)));
		plan.push_back(plan_typed(OP_START, 8'h01, 16'h0000, 32'd1, MODE_ONCE,
			single_rsp(KIND_STATUS, ST_NOT_FOUND)));
		plan.push_back(plan_typed(OP_STOP, 8'hFF, 16'hFFFF, 32'd0, MODE_ONCE,
			single_rsp(KIND_STATUS, ST_BAD_TASK)));
		plan.push_back(plan_item(OP_START, 8'h00, 16'h0000, 32'd1, MODE_ONCE));
		plan.push_back(plan_item(OP_ADVANCE, 8'h00, 16'h0000, 32'd0, MODE_ONCE));
		plan.push_back(plan_item(OP_SCAN, 8'h00, 16'h0000, 32'd0, MODE_ONCE));
		plan.push_back(plan_typed(OP_SCAN, 8'h00, 16'h0000, 32'd0, MODE_ONCE,
			single_rsp(KIND_SCAN, ST_OK)));
		// no valid task at all: bad task wins over zero match and bad mode
		plan.push_back(plan_write(REG_TASK_COUNT, 24'd0));
		plan.push_back(plan_typed(OP_START, 8'h00, 16'h0000, 32'd0, MODE_BAD_TWO,
			single_rsp(KIND_STATUS, ST_BAD_TASK)));
		// extreme bindings, a duplicate pair, channels in use above the table,
		// and a write to an index with no register behind it
		plan.push_back(plan_write(REG_TASK_COUNT, 24'd255));
		plan.push_back(plan_write(REG_TIMERS_IN_USE, 24'd7));
		plan.push_back(plan_write(REG_BINDING_ZERO, 24'hFFFFFF));
		plan.push_back(plan_write(REG_BINDING_ZERO + 3'd1, 24'h010002));
		plan.push_back(plan_write(REG_BINDING_ZERO + 3'd2, 24'h010002));
		plan.push_back(plan_write(REG_BINDING_ZERO + 3'd3, 24'hFEFFFF));
		plan.push_back(plan_write(REG_UNUSED, 24'h123456));
		plan.push_back(plan_item(OP_START, 8'hFE, 16'hFFFF, 32'hFFFFFFFF, MODE_PERIODIC));
		plan.push_back(plan_item(OP_START, 8'h01, 16'h0002, 32'd2, MODE_PERIODIC));
		plan.push_back(plan_typed(OP_START, 8'hFF, 16'hFFFF, 32'd1, MODE_ONCE,
			single_rsp(KIND_STATUS, ST_BAD_TASK)));
		plan.push_back(plan_item(OP_ADVANCE, 8'h00, 16'h0000, 32'd0, MODE_ONCE));
		plan.push_back(plan_item(OP_ADVANCE, 8'h00, 16'h0000, 32'd0, MODE_ONCE));
		plan.push_back(plan_item(OP_SCAN, 8'h00, 16'h0000, 32'd0, MODE_ONCE));
		plan.push_back(plan_item(OP_ADVANCE, 8'h00, 16'h0000, 32'd0, MODE_ONCE));
		plan.push_back(plan_item(OP_ADVANCE, 8'h00, 16'h0000, 32'd0, MODE_ONCE));
		plan.push_back(plan_item(OP_SCAN, 8'h00, 16'h0000, 32'd0, MODE_ONCE));
		// stop ignores match value and mode; a second stop still finds it
		plan.push_back(plan_item(OP_STOP, 8'h01, 16'h0002, 32'd0, MODE_BAD_THREE));
		plan.push_back(plan_item(OP_STOP, 8'h01, 16'h0002, 32'd5, MODE_ONCE));
		plan.push_back(plan_item(OP_SCAN, 8'h00, 16'h0000, 32'd0, MODE_ONCE));
		// no channel in use: nothing is found and nothing fires
		plan.push_back(plan_write(REG_TIMERS_IN_USE, 24'd0));
		plan.push_back(plan_typed(OP_STOP, 8'hFE, 16'hFFFF, 32'd0, MODE_ONCE,
			single_rsp(KIND_STATUS, ST_NOT_FOUND)));
		plan.push_back(plan_typed(OP_SCAN, 8'h00, 16'h0000, 32'd0, MODE_ONCE,
			single_rsp(KIND_SCAN, ST_OK)));

		idle_pct = 25;
		foreach (plan[k]) begin
			if (plan[k].is_write) begin
				drain_block();
				write_register(plan[k].reg_idx, plan[k].reg_val);
			end else begin
				send_request(plan[k].item, plan[k].typed, plan[k].typed_rsp);
			end
		end

		// Random part, one register setting per phase
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			for (int i = 0; i < NUM_TIMERS; i++)
				b[i] = {8'($urandom_range(0, 40)), 16'($urandom)};
			case (ph)
				0: begin
					tc = 8'd255;
					tiu = 3'd4;
				end
				1: begin
					tc = 8'd0;
					tiu = 3'd4;
				end
				2: begin
					tc = 8'd200;
					tiu = 3'd1;
				end
				3: begin
					tc = 8'($urandom_range(20, 60));
					tiu = 3'd7;
					b[2] = b[0];
				end
				4: begin
					tc = 8'd255;
					tiu = 3'd0;
				end
				default: begin
					tc = 8'd255;
					tiu = 3'd4;
					b[0] = 24'hFFFFFF;
					b[1] = 24'h000000;
					b[3] = 24'hFEFFFF;
				end
			endcase
			// no idling in the third phase and in the closing stretch
			idle_pct = (ph == 2 || ph == NUM_PHASES - 1) ? 0 : 25;
			drain_block();
			write_register(REG_TASK_COUNT, 24'(tc));
			write_register(REG_TIMERS_IN_USE, 24'(tiu));
			for (int i = 0; i < NUM_TIMERS; i++)
				write_register(REG_BINDING_ZERO + 3'(i), b[i]);
			for (int n = 0; n < phase_items[ph]; n++) begin
				// let the receiver hold off while requests keep coming
				if (ph == 0 && n == 30)
					hold_off_req = 1'b1;
				send_request(random_request(), 1'b0, none);
			end
		end

		drain_block();
		if (awaited_reports.size() != 0)
			report_mismatch("responses never seen", awaited_reports.size(), 0);
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Timeout guard
	initial begin
		#(TIMEOUT_NS);
		$display("TB_ERROR");
		$finish;
	end

endmodule
